/* rtl/rsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_pkg
// Widths, class codes and the queue word shared by the ray/sphere hit test.
// ----------------------------------------------------------------------------
package rsh_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int AXES       = 3;

  localparam int RAD_BITS = COORD_BITS - 1;      // radius, unsigned
  localparam int VB       = COORD_BITS + 1;      // origin - center
  localparam int DVB      = COORD_BITS + VB;     // dir * v
  localparam int SQB      = 2 * VB;              // v * v
  localparam int RRB      = 2 * RAD_BITS;        // r * r
  localparam int DOTB     = DVB + 2;             // sum of three dir * v
  localparam int CW       = SQB + 2;             // sum of squares minus r*r, signed

  // magnitude of dot(dir, v) once known to be non-positive
  localparam int MAGB = DOTB;
  localparam int LOB  = (MAGB + 1) / 2;
  localparam int HIB  = MAGB - LOB;
  localparam int HHB  = 2 * HIB;
  localparam int HLB  = HIB + LOB;
  localparam int LLB  = 2 * LOB;
  localparam int CSB  = CW - 1 + 2 * FRAC_BITS;
  localparam int CMPB = (2 * MAGB > CSB) ? 2 * MAGB : CSB;

  localparam int QDEPTH = 4;
  localparam int QPTRW  = $clog2(QDEPTH);
  localparam int QCNTW  = $clog2(QDEPTH + 1);

  // outcome class decided in the front end
  localparam int CLSW = 2;
  localparam logic [CLSW-1:0] CLS_HIT  = 2'd0;   // origin inside or on the sphere
  localparam logic [CLSW-1:0] CLS_MISS = 2'd1;   // outside, sphere behind
  localparam logic [CLSW-1:0] CLS_TEST = 2'd2;   // outside, ahead: check discriminant

  typedef struct packed {
    logic [CLSW-1:0] cls;
    logic [MAGB-1:0] mag;    // -dot(dir, v)
    logic [CW-2:0]   cpos;   // c, positive when cls is CLS_TEST
  } job_t;

endpackage

/* rtl/rsh_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_in_if
// Input channel: one ray and one sphere per word.
// ----------------------------------------------------------------------------
interface rsh_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rsh_pkg::COORD_BITS-1:0] origin_x;
  logic signed [rsh_pkg::COORD_BITS-1:0] origin_y;
  logic signed [rsh_pkg::COORD_BITS-1:0] origin_z;
  logic signed [rsh_pkg::COORD_BITS-1:0] dir_x;
  logic signed [rsh_pkg::COORD_BITS-1:0] dir_y;
  logic signed [rsh_pkg::COORD_BITS-1:0] dir_z;
  logic signed [rsh_pkg::COORD_BITS-1:0] center_x;
  logic signed [rsh_pkg::COORD_BITS-1:0] center_y;
  logic signed [rsh_pkg::COORD_BITS-1:0] center_z;
  logic        [rsh_pkg::RAD_BITS-1:0]   radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    output ready
  );
endinterface

/* rtl/rsh_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_out_if
// Result channel: one hit flag per word.
// ----------------------------------------------------------------------------
interface rsh_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

/* rtl/ray_sphere_hit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_hit_test
// Ray against sphere hit test in signed fixed point, one test per word.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries a ray origin, a direction and a sphere center (signed,
//   COORD_BITS wide with FRAC_BITS fraction bits) and a radius (unsigned).
//   out_ch returns one hit flag per input word, in input order.
//   Both channels move a word on a clock edge where valid and ready are high.
//   From the accepting edge a word passes the front end stages, the queue
//   and the back end stages to out_ch.valid. Throughput is one word per
//   cycle while out_ch.ready stays high: the front end (differences,
//   products, sums, classification) and the back end (square of dot(dir, v)
//   from three partial products, compare, output register) are each fully pipelined.
//   A four-word queue sits between them. When out_ch.ready is low the back
//   end holds its result; the front end keeps taking words until the queue
//   is full and a word waits in its last stage, then in_ch.ready drops.
//   rst_n is synchronous and active low; it empties every stage and the
//   queue, and in_ch.ready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module ray_sphere_hit_test (
  input  logic       clk,
  input  logic       rst_n,
  rsh_in_if.sink     in_ch,
  rsh_out_if.source  out_ch
);

  logic          push_valid, push_ready;
  rsh_pkg::job_t push_job;
  logic          pop_valid, pop_ready;
  rsh_pkg::job_t pop_job;

  rsh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  rsh_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  rsh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/rsh_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_front
// Front end: accepts words, forms dot(dir, v) and c, classifies the outcome.
// ----------------------------------------------------------------------------
module rsh_front (
  input  logic           clk,
  input  logic           rst_n,
  rsh_in_if.sink         in_ch,
  output logic           push_valid,
  input  logic           push_ready,
  output rsh_pkg::job_t  push_job
);

  logic en;

  logic s1_valid_r, s2_valid_r, s3_valid_r;

  logic signed [rsh_pkg::COORD_BITS-1:0] o_w [rsh_pkg::AXES];
  logic signed [rsh_pkg::COORD_BITS-1:0] s_w [rsh_pkg::AXES];
  logic signed [rsh_pkg::COORD_BITS-1:0] d_w [rsh_pkg::AXES];

  // stage 1: differences
  logic signed [rsh_pkg::VB-1:0]         v_r   [rsh_pkg::AXES];
  logic signed [rsh_pkg::VB-1:0]         v_nxt [rsh_pkg::AXES];
  logic signed [rsh_pkg::COORD_BITS-1:0] d_r   [rsh_pkg::AXES];
  logic        [rsh_pkg::RAD_BITS-1:0]   rad_r;

  // stage 2: products
  logic signed [rsh_pkg::DVB-1:0] dv_r   [rsh_pkg::AXES];
  logic signed [rsh_pkg::DVB-1:0] dv_nxt [rsh_pkg::AXES];
  logic signed [rsh_pkg::SQB-1:0] sq_r   [rsh_pkg::AXES];
  logic signed [rsh_pkg::SQB-1:0] sq_nxt [rsh_pkg::AXES];
  logic        [rsh_pkg::RRB-1:0] rr_r, rr_nxt;

  // stage 3: sums
  logic signed [rsh_pkg::DOTB-1:0] dot_r, dot_nxt;
  logic signed [rsh_pkg::CW-1:0]   c_r, c_nxt;

  logic c_nonpos, dot_pos;

  assign en          = !s3_valid_r || push_ready;
  assign in_ch.ready = en;

  assign o_w[0] = in_ch.origin_x;
  assign o_w[1] = in_ch.origin_y;
  assign o_w[2] = in_ch.origin_z;
  assign s_w[0] = in_ch.center_x;
  assign s_w[1] = in_ch.center_y;
  assign s_w[2] = in_ch.center_z;
  assign d_w[0] = in_ch.dir_x;
  assign d_w[1] = in_ch.dir_y;
  assign d_w[2] = in_ch.dir_z;

  always_comb begin
    for (int i = 0; i < rsh_pkg::AXES; i++) begin
      v_nxt[i]  = rsh_pkg::VB'(o_w[i]) - rsh_pkg::VB'(s_w[i]);
      dv_nxt[i] = rsh_pkg::DVB'(d_r[i]) * rsh_pkg::DVB'(v_r[i]);
      sq_nxt[i] = rsh_pkg::SQB'(v_r[i]) * rsh_pkg::SQB'(v_r[i]);
    end
    rr_nxt  = rsh_pkg::RRB'(rad_r) * rsh_pkg::RRB'(rad_r);
    dot_nxt = rsh_pkg::DOTB'(dv_r[0]) + rsh_pkg::DOTB'(dv_r[1])
            + rsh_pkg::DOTB'(dv_r[2]);
    c_nxt   = rsh_pkg::CW'(sq_r[0]) + rsh_pkg::CW'(sq_r[1]) + rsh_pkg::CW'(sq_r[2])
            - rsh_pkg::CW'(rr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      d_r   <= d_w;
      rad_r <= in_ch.radius;
      dv_r  <= dv_nxt;
      sq_r  <= sq_nxt;
      rr_r  <= rr_nxt;
      dot_r <= dot_nxt;
      c_r   <= c_nxt;
    end
  end

  // inside or on the sphere wins, then a sphere behind the origin misses
  assign c_nonpos = c_r[rsh_pkg::CW-1] || (c_r == '0);
  assign dot_pos  = !dot_r[rsh_pkg::DOTB-1] && (dot_r != '0);

  always_comb begin
    if (c_nonpos) begin
      push_job.cls = rsh_pkg::CLS_HIT;
    end else if (dot_pos) begin
      push_job.cls = rsh_pkg::CLS_MISS;
    end else begin
      push_job.cls = rsh_pkg::CLS_TEST;
    end
    push_job.mag  = rsh_pkg::MAGB'(-dot_r);
    push_job.cpos = c_r[rsh_pkg::CW-2:0];
  end

  assign push_valid = s3_valid_r;

endmodule

/* rtl/rsh_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_fifo
// Short queue of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
module rsh_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rsh_pkg::job_t  push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rsh_pkg::job_t  pop_job
);

  rsh_pkg::job_t mem_r [rsh_pkg::QDEPTH];

  logic [rsh_pkg::QPTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rsh_pkg::QPTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rsh_pkg::QCNTW-1:0] count_r, count_nxt;
  logic push_fire, pop_fire;

  assign push_ready = (count_r != rsh_pkg::QCNTW'(rsh_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_job    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_fire ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_fire  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rsh_pkg::QCNTW'(rsh_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

/* rtl/rsh_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsh_back
// Back end: squares -dot(dir, v) from partial products, compares with c,
// and holds the result word.
// ----------------------------------------------------------------------------
module rsh_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  rsh_pkg::job_t  pop_job,
  rsh_out_if.source      out_ch
);

  logic en;

  logic b1_valid_r, b2_valid_r, out_valid_r;
  logic out_hit_r, out_hit_nxt;

  logic [rsh_pkg::LOB-1:0] lo_w;
  logic [rsh_pkg::HIB-1:0] hi_w;

  // stage 1: partial products
  logic [rsh_pkg::CLSW-1:0] b1_cls_r;
  logic [rsh_pkg::CW-2:0]   b1_cpos_r;
  logic [rsh_pkg::HHB-1:0]  hh_r, hh_nxt;
  logic [rsh_pkg::HLB-1:0]  hl_r, hl_nxt;
  logic [rsh_pkg::LLB-1:0]  ll_r, ll_nxt;

  // stage 2: square and scaled c
  logic [rsh_pkg::CLSW-1:0] b2_cls_r;
  logic [rsh_pkg::CMPB-1:0] sq_r, sq_nxt;
  logic [rsh_pkg::CMPB-1:0] cs_r, cs_nxt;

  assign en        = !out_valid_r || out_ch.ready;
  assign pop_ready = en;

  assign lo_w = pop_job.mag[rsh_pkg::LOB-1:0];
  assign hi_w = pop_job.mag[rsh_pkg::MAGB-1:rsh_pkg::LOB];

  always_comb begin
    hh_nxt = rsh_pkg::HHB'(hi_w) * rsh_pkg::HHB'(hi_w);
    hl_nxt = rsh_pkg::HLB'(hi_w) * rsh_pkg::HLB'(lo_w);
    ll_nxt = rsh_pkg::LLB'(lo_w) * rsh_pkg::LLB'(lo_w);
    // (hi*2^k + lo)^2 = hi^2*2^2k + 2*hi*lo*2^k + lo^2
    sq_nxt = (rsh_pkg::CMPB'(hh_r) << (2 * rsh_pkg::LOB))
           + (rsh_pkg::CMPB'(hl_r) << (rsh_pkg::LOB + 1))
           + rsh_pkg::CMPB'(ll_r);
    cs_nxt = rsh_pkg::CMPB'(b1_cpos_r) << (2 * rsh_pkg::FRAC_BITS);
    case (b2_cls_r)
      rsh_pkg::CLS_HIT:  out_hit_nxt = 1'b1;
      rsh_pkg::CLS_MISS: out_hit_nxt = 1'b0;
      rsh_pkg::CLS_TEST: out_hit_nxt = (sq_r >= cs_r);
      default:           out_hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_valid_r  <= pop_valid;
      b2_valid_r  <= b1_valid_r;
      out_valid_r <= b2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_cls_r  <= pop_job.cls;
      b1_cpos_r <= pop_job.cpos;
      hh_r      <= hh_nxt;
      hl_r      <= hl_nxt;
      ll_r      <= ll_nxt;
      b2_cls_r  <= b1_cls_r;
      sq_r      <= sq_nxt;
      cs_r      <= cs_nxt;
      out_hit_r <= out_hit_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;

  a_inside_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (en && b2_valid_r && b2_cls_r == rsh_pkg::CLS_HIT) |=> (out_valid_r && out_hit_r))
    else $error("inside case did not report a hit");

  a_behind_misses: assert property (@(posedge clk) disable iff (!rst_n)
    (en && b2_valid_r && b2_cls_r == rsh_pkg::CLS_MISS) |=> (out_valid_r && !out_hit_r))
    else $error("sphere behind reported a hit");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ray_sphere_hit_test. It starts with a short table of
// corner geometries, then runs random scenes: tangent rays, rays from inside,
// nearby rays, still rays, far-off and raw noise. Words go in bursts with gaps,
// and the result side stalls in changing patterns. Every hit flag is compared,
// in order, with the table's expected flag or an exact full-width evaluation of the quadratic test.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_RANDOM     = 1600;
  localparam int N_DIRECTED   = 22;
  localparam int DOG_LIMIT    = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef logic signed [rsh_pkg::COORD_BITS-1:0] coord_t;
  typedef logic signed [255:0]                   exact_t;
  typedef logic [rsh_pkg::RAD_BITS-1:0]          rad_t;

  localparam coord_t C_MAX = {1'b0, {(rsh_pkg::COORD_BITS-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(rsh_pkg::COORD_BITS-1){1'b0}}};
  localparam coord_t ONE   = coord_t'(1 <<< rsh_pkg::FRAC_BITS);
  localparam coord_t TEN   = 10 * ONE;
  localparam rad_t   R_MAX = '1;
  localparam rad_t   R_ONE = rad_t'(1 << rsh_pkg::FRAC_BITS);

  typedef enum logic [1:0] {WANT_MISS, WANT_HIT, WANT_CALC} want_e;
  typedef enum int {STALL_NONE, STALL_COIN, STALL_MASK, STALL_LONG} stall_e;
  typedef enum int {
    SCENE_NOISE, SCENE_FAR, SCENE_NEAR, SCENE_GRAZE, SCENE_INSIDE, SCENE_STILL
  } scene_e;

  typedef struct packed {
    coord_t ox, oy, oz;
    coord_t dx, dy, dz;
    coord_t cx, cy, cz;
    rad_t   radius;
  } probe_t;

  typedef struct packed {
    probe_t p;
    want_e  want;
  } row_t;

  // origin xyz, direction xyz, center xyz, radius, expected flag
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, WANT_HIT},
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, R_MAX}, WANT_HIT},
    '{'{C_MAX, 0, 0, 0, 0, 0, C_MIN, 0, 0, 0}, WANT_MISS},
    '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, R_MAX}, WANT_HIT},
    '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 0}, WANT_HIT},
    '{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, R_MAX}, WANT_CALC},
    '{'{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, R_MAX}, WANT_CALC},
    '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0}, WANT_MISS},
    '{'{0, 0, -TEN, 0, 0, ONE, 0, 0, 0, R_ONE}, WANT_CALC},
    '{'{0, 0, -TEN, 0, 0, -ONE, 0, 0, 0, R_ONE}, WANT_MISS},
    '{'{ONE, 0, -TEN, 0, 0, ONE, 0, 0, 0, R_ONE}, WANT_HIT},
    '{'{ONE + 1, 0, -TEN, 0, 0, ONE, 0, 0, 0, R_ONE}, WANT_MISS},
    '{'{ONE, 0, 0, 0, 0, 0, 0, 0, 0, 2 * R_ONE}, WANT_HIT},
    '{'{ONE, 0, 0, 0, 0, 0, 0, 0, 0, R_ONE}, WANT_HIT},
    '{'{3 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, R_ONE}, WANT_MISS},
    '{'{TEN, 0, -TEN, 0, 0, ONE, 0, 0, 0, R_ONE}, WANT_CALC},
    '{'{0, 0, -TEN, 0, 0, C_MAX, 0, 0, 0, R_ONE}, WANT_CALC},
    '{'{0, 0, -TEN, 0, 0, 1, 0, 0, 0, R_ONE}, WANT_CALC},
    '{'{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
        32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA}, WANT_CALC},
    '{'{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
        32'h55555555, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 31'h55555555}, WANT_CALC},
    '{'{ONE, 0, 0, ONE, 0, 0, 0, 0, 0, R_ONE}, WANT_HIT},
    '{'{ONE, ONE, 0, ONE, ONE, 0, 0, 0, 0, 3 * R_ONE}, WANT_HIT}
  };

  logic clk;
  logic rst_n;

  rsh_in_if  in_ch ();
  rsh_out_if out_ch ();

  ray_sphere_hit_test u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic  hit_expect_q [$];
  want_e next_want;
  int    mismatches;
  int    burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact quadratic test at 256 bits, nothing can overflow
  function automatic logic predict_hit(input probe_t p);
    coord_t o [3];
    coord_t d [3];
    coord_t s [3];
    exact_t ov, dv, sv, v, dot, c, rr;
    o = '{p.ox, p.oy, p.oz};
    d = '{p.dx, p.dy, p.dz};
    s = '{p.cx, p.cy, p.cz};
    dot = '0;
    c   = '0;
    for (int i = 0; i < 3; i++) begin
      ov = exact_t'(o[i]);
      dv = exact_t'(d[i]);
      sv = exact_t'(s[i]);
      v  = ov - sv;
      dot += dv * v;
      c   += v * v;
    end
    rr = exact_t'(p.radius);
    c -= rr * rr;
    if (c <= 0) return 1'b1;
    if (dot > 0) return 1'b0;
    return (dot * dot) >= (c <<< (2 * rsh_pkg::FRAC_BITS));
  endfunction

  function automatic coord_t spread(input int unsigned span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  function automatic probe_t random_probe();
    probe_t p;
    scene_e scene;
    int     pick, r, k, s;
    pick = $urandom_range(0, 19);
    if (pick < 3)       scene = SCENE_NOISE;
    else if (pick < 5)  scene = SCENE_FAR;
    else if (pick < 12) scene = SCENE_NEAR;
    else if (pick < 16) scene = SCENE_GRAZE;
    else if (pick < 18) scene = SCENE_INSIDE;
    else                scene = SCENE_STILL;
    case (scene)
      SCENE_NOISE: begin
        p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, rad_t'($urandom)};
      end
      SCENE_FAR: begin
        p.ox = $urandom;
        p.oy = $urandom;
        p.oz = $urandom;
        p.cx = p.ox + spread(1 << 24);
        p.cy = p.oy + spread(1 << 24);
        p.cz = p.oz + spread(1 << 24);
        p.dx = $urandom;
        p.dy = $urandom;
        p.dz = $urandom;
        p.radius = rad_t'($urandom_range(0, 1 << 26));
      end
      SCENE_GRAZE: begin
        // ray along z passing the sphere at r-1, r or r+1 from its axis
        r = $urandom_range(1, 1 << 20);
        k = $urandom_range(1, 1 << 20);
        s = $urandom_range(0, 1) ? 1 : -1;
        p.cx = spread(1 << 28);
        p.cy = spread(1 << 28);
        p.cz = spread(1 << 28);
        p.ox = p.cx + r + int'($urandom_range(0, 2)) - 1;
        p.oy = p.cy;
        p.oz = p.cz - s * k;
        p.dx = 0;
        p.dy = 0;
        p.dz = s * ONE;
        p.radius = rad_t'(r);
      end
      SCENE_INSIDE: begin
        p.cx = spread(1 << 28);
        p.cy = spread(1 << 28);
        p.cz = spread(1 << 28);
        p.ox = p.cx + spread(1 << 20);
        p.oy = p.cy + spread(1 << 20);
        p.oz = p.cz + spread(1 << 20);
        p.dx = spread(ONE);
        p.dy = spread(ONE);
        p.dz = spread(ONE);
        p.radius = rad_t'($urandom_range(1 << 21, 1 << 30));
      end
      default: begin
        p.cx = spread(1 << 22);
        p.cy = spread(1 << 22);
        p.cz = spread(1 << 22);
        p.ox = spread(1 << 22);
        p.oy = spread(1 << 22);
        p.oz = spread(1 << 22);
        p.dx = (scene == SCENE_STILL) ? coord_t'(0) : spread(ONE);
        p.dy = (scene == SCENE_STILL) ? coord_t'(0) : spread(ONE);
        p.dz = (scene == SCENE_STILL) ? coord_t'(0) : spread(ONE);
        p.radius = rad_t'($urandom_range(0, 1 << 22));
      end
    endcase
    return p;
  endfunction

  task automatic flag_error(input string what, input logic want, input logic got);
    if (mismatches < 10) $display("%0t %s: expected %b got %b", $time, what, want, got);
    mismatches++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input probe_t p, input want_e w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.origin_x <= p.ox;
    in_ch.origin_y <= p.oy;
    in_ch.origin_z <= p.oz;
    in_ch.dir_x    <= p.dx;
    in_ch.dir_y    <= p.dy;
    in_ch.dir_z    <= p.dz;
    in_ch.center_x <= p.cx;
    in_ch.center_y <= p.cy;
    in_ch.center_z <= p.cz;
    in_ch.radius   <= p.radius;
    in_ch.valid    <= 1'b1;
    next_want      <= w;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // result side back-pressure, each pattern held for a random span
  initial begin : result_stall
    stall_e      mode;
    int          span, phase;
    logic [15:0] mask;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      mode = stall_e'($urandom_range(0, 3));
      span = $urandom_range(20, 120);
      mask = 16'($urandom);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          STALL_NONE: out_ch.ready <= 1'b1;
          STALL_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
          STALL_MASK: out_ch.ready <= mask[phase[3:0]];
          default:    out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
        phase++;
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    probe_t seen;
    logic   want_hit;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (hit_expect_q.size() == 0) begin
          flag_error("hit flag with nothing pending", 1'bx, out_ch.hit);
        end else begin
          want_hit = hit_expect_q.pop_front();
          if (out_ch.hit !== want_hit) flag_error("hit flag mismatch", want_hit, out_ch.hit);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z,
                 in_ch.dir_x, in_ch.dir_y, in_ch.dir_z,
                 in_ch.center_x, in_ch.center_y, in_ch.center_z, in_ch.radius};
        case (next_want)
          WANT_HIT:  hit_expect_q.push_back(1'b1);
          WANT_MISS: hit_expect_q.push_back(1'b0);
          default:   hit_expect_q.push_back(predict_hit(seen));
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < DOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.origin_x = '0;
    in_ch.origin_y = '0;
    in_ch.origin_z = '0;
    in_ch.dir_x    = '0;
    in_ch.dir_y    = '0;
    in_ch.dir_z    = '0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.center_z = '0;
    in_ch.radius   = '0;
    next_want      = WANT_CALC;
    mismatches     = 0;
    burst_left     = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) offer(DIRECTED[i].p, DIRECTED[i].want);
    for (int i = 0; i < N_RANDOM; i++) offer(random_probe(), WANT_CALC);
    in_ch.valid <= 1'b0;

    while (hit_expect_q.size() != 0) @(posedge clk);
    // stray words after the last expected one still get flagged
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && hit_expect_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
